[src/dwmd_pkg.sv]
package dwmd_pkg;

  // Fixed field widths
  localparam int SYM_W     = 5;
  localparam int WL_W      = 5;
  localparam int OUT_POS_W = 16;

  // Defaults for the top-level parameters
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int POSITION_BITS_DEF = 16;

  // Window length after reset
  localparam logic [WL_W-1:0] WL_RESET = WL_W'(14);

  // Table control bundle from the line tracker
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } tbl_ctl_t;

endpackage

[src/dwmd_in_if.sv]
interface dwmd_in_if;
  logic                      valid;
  logic                      ready;
  logic [dwmd_pkg::SYM_W-1:0] symbol;
  logic                      end_of_line;

  modport source (output valid, output symbol, output end_of_line, input ready);
  modport sink (input valid, input symbol, input end_of_line, output ready);
endinterface

[src/dwmd_out_if.sv]
interface dwmd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          marker_found;
  logic [dwmd_pkg::OUT_POS_W-1:0] marker_position;

  modport source (output valid, output marker_found, output marker_position, input ready);
  modport sink (input valid, input marker_found, input marker_position, output ready);
endinterface

[src/dwmd_table.sv]
module dwmd_table #(
  parameter int ALPHABET_SIZE = dwmd_pkg::ALPHABET_SIZE_DEF,
  parameter int POSITION_BITS = dwmd_pkg::POSITION_BITS_DEF,
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dwmd_pkg::tbl_ctl_t       ctl,
  input  logic [AW-1:0]            rd_addr,
  input  logic [AW-1:0]            wr_addr,
  input  logic [POSITION_BITS-1:0] wr_data,
  output logic [POSITION_BITS-1:0] prev_pos
);

  logic [POSITION_BITS-1:0] mem [ALPHABET_SIZE];
  logic [POSITION_BITS-1:0] rdata_r;
  logic [AW-1:0]            rd_addr_r;
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic                     fwd_hit_r;
  logic [POSITION_BITS-1:0] fwd_pos_r;

  // Write last-seen position
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; catch a write to the same entry at that edge
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
      fwd_pos_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_hit_r <= ctl.wr_en && (wr_addr == rd_addr);
    end
  end

  // Entry valid bits; end of line clears them all, overriding a write
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Never-seen entries read as zero
  always_comb begin
    if (!valid_r[rd_addr_r]) begin
      prev_pos = '0;
    end else if (fwd_hit_r) begin
      prev_pos = fwd_pos_r;
    end else begin
      prev_pos = rdata_r;
    end
  end

endmodule

[src/distinct_window_marker_detector.sv]
// A result passes through the stage-1 register and then the output register.
// Throughput: one symbol per cycle when not stalled; the last-seen table is read
// at acceptance and written back as the symbol leaves stage 1, with forwarding
// for back-to-back repeats. Input stalls only while a result waits in the output
// register and another is due. Reset: window length 14, line state and table
// valid bits cleared; no clearing pass over the table.
module distinct_window_marker_detector #(
  parameter int ALPHABET_SIZE = dwmd_pkg::ALPHABET_SIZE_DEF,
  parameter int POSITION_BITS = dwmd_pkg::POSITION_BITS_DEF,
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dwmd_in_if.sink                    in_s,
  dwmd_out_if.source                 out_s,
  input  logic                       cfg_wr_en,
  input  logic [dwmd_pkg::WL_W-1:0]  cfg_wr_data
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic                         accept;
  logic                         s1_valid_r;
  logic [dwmd_pkg::SYM_W-1:0]   s1_sym_r;
  logic                         s1_eol_r;
  logic [POSITION_BITS-1:0]     count_r;
  logic [POSITION_BITS-1:0]     floor_r;
  logic                         reported_r;
  logic [dwmd_pkg::WL_W-1:0]    wl_r;
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [dwmd_pkg::OUT_POS_W-1:0] out_pos_r;

  logic                         in_range;
  logic [POSITION_BITS-1:0]     pos;
  logic [POSITION_BITS-1:0]     prev_pos;
  logic [POSITION_BITS-1:0]     floor_nxt;
  logic [dwmd_pkg::WL_W-1:0]    need;
  logic                         hit;
  logic                         emit;
  logic                         s1_adv;
  dwmd_pkg::tbl_ctl_t           tbl_ctl;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= dwmd_pkg::WL_RESET;
    end else if (cfg_wr_en) begin
      wl_r <= cfg_wr_data;
    end
  end

  // Input handshake
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign accept     = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sym_r <= in_s.symbol;
      s1_eol_r <= in_s.end_of_line;
    end
  end

  // Last-seen table
  assign tbl_ctl.rd_en = accept;
  assign tbl_ctl.wr_en = s1_adv && in_range;
  assign tbl_ctl.clr   = s1_adv && s1_eol_r;

  dwmd_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .POSITION_BITS (POSITION_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .rd_addr  (AW'(in_s.symbol)),
    .wr_addr  (AW'(s1_sym_r)),
    .wr_data  (pos),
    .prev_pos (prev_pos)
  );

  // Position, repeat floor and window test
  always_comb begin
    in_range  = int'(s1_sym_r) < ALPHABET_SIZE;
    pos       = (count_r < POS_MAX) ? count_r + 1'b1 : count_r;
    if (!in_range) begin
      floor_nxt = pos;
    end else if (prev_pos > floor_r) begin
      floor_nxt = prev_pos;
    end else begin
      floor_nxt = floor_r;
    end
    need   = (wl_r == '0) ? dwmd_pkg::WL_W'(1) : wl_r;
    hit    = !reported_r && ((pos - floor_nxt) >= POSITION_BITS'(need));
    emit   = !reported_r && (hit || s1_eol_r);
    s1_adv = s1_valid_r && (!emit || !out_valid_r || out_s.ready);
  end

  // Line state: advance, or clear at end of line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      floor_r    <= '0;
      reported_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_eol_r) begin
        count_r    <= '0;
        floor_r    <= '0;
        reported_r <= 1'b0;
      end else begin
        count_r    <= pos;
        floor_r    <= floor_nxt;
        reported_r <= reported_r || hit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_found_r <= hit;
      out_pos_r   <= hit ? dwmd_pkg::OUT_POS_W'(pos) : '0;
    end
  end

  assign out_s.valid           = out_valid_r;
  assign out_s.marker_found    = out_found_r;
  assign out_s.marker_position = out_pos_r;

endmodule
